// ----- sv/tlne_pkg.sv -----
package tlne_pkg;

   localparam int CANDIDATE_SLOTS = 128;
   localparam int HIDDEN_NEURONS  = 6;
   localparam int NET_INPUTS      = 8;
   localparam int NET_FEATURES    = NET_INPUTS - 1;
   localparam int NET_OUTPUTS     = 3;
   localparam int HID_WEIGHTS     = HIDDEN_NEURONS * NET_INPUTS;
   localparam int SLOT_WEIGHTS    = HID_WEIGHTS + NET_OUTPUTS * HIDDEN_NEURONS;

   localparam int SLOT_W     = 7;
   localparam int INDEX_W    = 7;
   localparam int WEIGHT_W   = 16;
   localparam int FEAT_W     = 32;
   localparam int VAL_W      = 48;
   localparam int PROD_W     = VAL_W + WEIGHT_W;
   localparam int FRAC_SHIFT = 11;
   localparam int TERM_W     = PROD_W - FRAC_SHIFT;
   localparam int SUM_W      = TERM_W + 1;
   localparam int BIAS_FRAC  = 20;

   localparam int LANES   = (HIDDEN_NEURONS > NET_OUTPUTS) ? HIDDEN_NEURONS : NET_OUTPUTS;
   localparam int LANE_W  = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int ROW_BITS = LANES * WEIGHT_W;
   localparam int ROWS    = NET_INPUTS + HIDDEN_NEURONS;
   localparam int ROW_W   = $clog2(ROWS);
   localparam int DEPTH   = CANDIDATE_SLOTS * (2 ** ROW_W);
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_MAX = (NET_INPUTS > HIDDEN_NEURONS) ? NET_INPUTS : HIDDEN_NEURONS;
   localparam int CNT_W   = $clog2(CNT_MAX);
   localparam int INP_W   = $clog2(NET_INPUTS);
   localparam int HID_W   = (HIDDEN_NEURONS > 1) ? $clog2(HIDDEN_NEURONS) : 1;

   localparam logic signed [VAL_W-1:0] BIAS_ONE = VAL_W'(1) << BIAS_FRAC;
   localparam logic signed [VAL_W-1:0] VAL_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN  = {1'b1, {(VAL_W-1){1'b0}}};

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   localparam int UPC_W = 3;
   localparam logic [UPC_W-1:0] STEP_IDLE  = 3'd0;
   localparam logic [UPC_W-1:0] STEP_HID   = 3'd1;
   localparam logic [UPC_W-1:0] STEP_WAITA = 3'd2;
   localparam logic [UPC_W-1:0] STEP_WAITB = 3'd3;
   localparam logic [UPC_W-1:0] STEP_HOLD  = 3'd4;
   localparam logic [UPC_W-1:0] STEP_OUT   = 3'd5;
   localparam logic [UPC_W-1:0] STEP_DONE  = 3'd6;

   typedef struct packed {
      logic                       cmd;
      logic [SLOT_W-1:0]          slot;
      logic [INDEX_W-1:0]         weight_index;
      logic signed [WEIGHT_W-1:0] weight_value;
      logic signed [FEAT_W-1:0]   feat_k;
      logic signed [FEAT_W-1:0]   feat_qq;
      logic signed [FEAT_W-1:0]   feat_x;
      logic signed [FEAT_W-1:0]   feat_t;
      logic signed [FEAT_W-1:0]   feat_f1;
      logic signed [FEAT_W-1:0]   feat_f2;
      logic signed [FEAT_W-1:0]   feat_dvcs;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] out_first;
      logic signed [VAL_W-1:0] out_second;
      logic signed [VAL_W-1:0] out_third;
   } rsp_type;

   typedef enum logic [2:0] {
      JMP_NEVER,
      JMP_ALWAYS,
      JMP_NO_EVAL,
      JMP_LOOP,
      JMP_BUSY
   } jmp_type;

   typedef struct packed {
      logic             issue;
      logic             out_phase;
      logic             cnt_inc;
      jmp_type          jmp;
      logic [UPC_W-1:0] tgt;
   } ucode_type;

   typedef struct packed {
      logic             issue;
      logic             out_phase;
      logic             first;
      logic             last;
      logic [CNT_W-1:0] cnt;
   } ctl_type;

   typedef struct packed {
      logic vld;
      logic out_phase;
      logic first;
      logic last;
   } tag_type;

   typedef struct packed {
      logic              ok;
      logic [ROW_W-1:0]  row;
      logic [LANE_W-1:0] lane;
   } wloc_type;

   function automatic ucode_type ucode(input logic [UPC_W-1:0] step);
      ucode_type u;
      u = '{issue: 1'b0, out_phase: 1'b0, cnt_inc: 1'b0, jmp: JMP_NEVER, tgt: STEP_IDLE};
      case (step)
         STEP_IDLE: begin
            u.jmp = JMP_NO_EVAL;
            u.tgt = STEP_IDLE;
         end
         STEP_HID: begin
            u.issue   = 1'b1;
            u.cnt_inc = 1'b1;
            u.jmp     = JMP_LOOP;
            u.tgt     = STEP_HID;
         end
         STEP_WAITA: u.jmp = JMP_NEVER;
         STEP_WAITB: u.jmp = JMP_NEVER;
         STEP_HOLD: begin
            u.jmp = JMP_BUSY;
            u.tgt = STEP_HOLD;
         end
         STEP_OUT: begin
            u.issue     = 1'b1;
            u.out_phase = 1'b1;
            u.cnt_inc   = 1'b1;
            u.jmp       = JMP_LOOP;
            u.tgt       = STEP_OUT;
         end
         STEP_DONE: begin
            u.jmp = JMP_ALWAYS;
            u.tgt = STEP_IDLE;
         end
         default: begin
            u.jmp = JMP_ALWAYS;
            u.tgt = STEP_IDLE;
         end
      endcase
      return u;
   endfunction

   // hidden weights: row = input, lane = neuron; output weights: row = 8 + neuron, lane = output
   function automatic wloc_type weight_loc(input logic [INDEX_W-1:0] idx);
      wloc_type r;
      int       j;
      int       o;
      r.ok = (32'(idx) < SLOT_WEIGHTS);
      j    = 32'(idx) - HID_WEIGHTS;
      o    = 0;
      if (32'(idx) < HID_WEIGHTS) begin
         r.row  = ROW_W'(32'(idx) % NET_INPUTS);
         r.lane = LANE_W'(32'(idx) / NET_INPUTS);
      end else begin
         for (int k = 1; k < NET_OUTPUTS; k++) begin
            if (j >= k * HIDDEN_NEURONS) o = k;
         end
         r.row  = ROW_W'(NET_INPUTS + j - o * HIDDEN_NEURONS);
         r.lane = LANE_W'(o);
      end
      return r;
   endfunction

   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] s);
      logic signed [VAL_W-1:0] r;
      if ((&s[SUM_W-1:VAL_W-1]) || !(|s[SUM_W-1:VAL_W-1])) begin
         r = s[VAL_W-1:0];
      end else if (s[SUM_W-1]) begin
         r = VAL_MIN;
      end else begin
         r = VAL_MAX;
      end
      return r;
   endfunction

endpackage

// ----- sv/tlne_sequencer.sv -----
module tlne_sequencer import tlne_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    eval_go,
   input  logic    rsp_full,
   output ctl_type ctl,
   output logic    idle
);

   logic [UPC_W-1:0] upc_ff;
   logic [UPC_W-1:0] upc_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   ucode_type        uc;
   logic             cnt_last;
   logic             take;

   assign uc = ucode(upc_ff);

   // loop end depends on the layer being walked
   assign cnt_last = uc.out_phase ? (cnt_ff == CNT_W'(HIDDEN_NEURONS - 1))
                                  : (cnt_ff == CNT_W'(NET_INPUTS - 1));

   always_comb begin
      case (uc.jmp)
         JMP_NEVER:   take = 1'b0;
         JMP_ALWAYS:  take = 1'b1;
         JMP_NO_EVAL: take = !eval_go;
         JMP_LOOP:    take = !cnt_last;
         JMP_BUSY:    take = rsp_full;
         default:     take = 1'b1;
      endcase
      upc_in = take ? uc.tgt : upc_ff + UPC_W'(1);
      cnt_in = cnt_ff;
      if (uc.cnt_inc) begin
         cnt_in = cnt_last ? '0 : cnt_ff + CNT_W'(1);
      end
   end

   always_comb begin
      ctl.issue     = uc.issue;
      ctl.out_phase = uc.out_phase;
      ctl.first     = (cnt_ff == '0);
      ctl.last      = cnt_last;
      ctl.cnt       = cnt_ff;
      idle          = (upc_ff == STEP_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_IDLE;
         cnt_ff <= '0;
      end else begin
         upc_ff <= upc_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- sv/tlne_datapath.sv -----
module tlne_datapath import tlne_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  logic    wr_en,
   input  logic    eval_go,
   input  ctl_type ctl,
   input  logic    rsp_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   output logic    rsp_full
);

   logic [ROW_BITS-1:0]     mem [DEPTH];
   logic [ROW_BITS-1:0]     rd_ff;
   wloc_type                wloc;
   logic [ADDR_W-1:0]       waddr;
   logic [ADDR_W-1:0]       raddr;
   logic [ROW_W-1:0]        row;

   logic [SLOT_W-1:0]       slot_ff;
   logic signed [FEAT_W-1:0] feat_ff [NET_FEATURES];
   logic signed [VAL_W-1:0] x_vec [NET_INPUTS];

   tag_type                 s1_ff;
   tag_type                 s1_in;
   tag_type                 s2_ff;
   logic signed [VAL_W-1:0] opnd_ff;
   logic signed [VAL_W-1:0] opnd_in;
   logic signed [PROD_W-1:0] prod_ff [LANES];
   logic signed [PROD_W-1:0] prod_in [LANES];
   logic signed [VAL_W-1:0] acc_ff [LANES];
   logic signed [VAL_W-1:0] acc_in [LANES];
   logic signed [VAL_W-1:0] hid_ff [HIDDEN_NEURONS];

   logic                    done;
   logic                    hid_done;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   rsp_type                 rsp_ff;

   // weight memory, one row per input or hidden neuron, one lane per neuron
   assign wloc  = weight_loc(req_data.weight_index);
   assign waddr = (ADDR_W'(req_data.slot) << ROW_W) | ADDR_W'(wloc.row);
   assign row   = ctl.out_phase ? ROW_W'(NET_INPUTS) + ROW_W'(ctl.cnt) : ROW_W'(ctl.cnt);
   assign raddr = (ADDR_W'(slot_ff) << ROW_W) | ADDR_W'(row);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[waddr][wloc.lane*WEIGHT_W +: WEIGHT_W] <= req_data.weight_value;
      end
      if (ctl.issue) begin
         rd_ff <= mem[raddr];
      end
   end

   always_comb begin
      for (int i = 0; i < NET_FEATURES; i++) begin
         x_vec[i] = VAL_W'(feat_ff[i]);
      end
      x_vec[NET_INPUTS-1] = BIAS_ONE;
      opnd_in = ctl.out_phase ? hid_ff[ctl.cnt[HID_W-1:0]] : x_vec[ctl.cnt[INP_W-1:0]];
      s1_in.vld       = ctl.issue;
      s1_in.out_phase = ctl.out_phase;
      s1_in.first     = ctl.first;
      s1_in.last      = ctl.last;
   end

   // one multiplier per lane, operand broadcast
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         prod_in[l] = PROD_W'(opnd_ff) * PROD_W'($signed(rd_ff[l*WEIGHT_W +: WEIGHT_W]));
      end
   end

   // floor shift then saturating accumulate
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         acc_in[l] = acc_ff[l];
         if (s2_ff.vld) begin
            acc_in[l] = sat_val((s2_ff.first ? SUM_W'(0) : SUM_W'(acc_ff[l]))
                                + SUM_W'($signed(prod_ff[l][PROD_W-1:FRAC_SHIFT])));
         end
      end
      hid_done     = s2_ff.vld && s2_ff.last && !s2_ff.out_phase;
      done         = s2_ff.vld && s2_ff.last && s2_ff.out_phase;
      rsp_valid_in = done || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld    <= 1'b0;
         s2_ff.vld    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_ff.vld    <= s1_in.vld;
         s2_ff.vld    <= s1_ff.vld;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_ff.out_phase <= s1_in.out_phase;
      s1_ff.first     <= s1_in.first;
      s1_ff.last      <= s1_in.last;
      s2_ff.out_phase <= s1_ff.out_phase;
      s2_ff.first     <= s1_ff.first;
      s2_ff.last      <= s1_ff.last;
   end

   always_ff @(posedge clock) begin
      opnd_ff         <= opnd_in;
      for (int l = 0; l < LANES; l++) begin
         prod_ff[l] <= prod_in[l];
         acc_ff[l]  <= acc_in[l];
      end
      if (hid_done) begin
         for (int h = 0; h < HIDDEN_NEURONS; h++) begin
            hid_ff[h] <= acc_in[h];
         end
      end
      if (done) begin
         rsp_ff.out_first  <= acc_in[0];
         rsp_ff.out_second <= acc_in[1];
         rsp_ff.out_third  <= acc_in[2];
      end
      if (eval_go) begin
         slot_ff    <= req_data.slot;
         feat_ff[0] <= req_data.feat_k;
         feat_ff[1] <= req_data.feat_qq;
         feat_ff[2] <= req_data.feat_x;
         feat_ff[3] <= req_data.feat_t;
         feat_ff[4] <= req_data.feat_f1;
         feat_ff[5] <= req_data.feat_f2;
         feat_ff[6] <= req_data.feat_dvcs;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_full  = rsp_valid_ff;

endmodule

// ----- sv/two_layer_linear_network_eval_unit.sv -----
// Forward pass of a two-layer linear network over weight sets kept for 128 candidate slots.
// A weight write request stores one Q5.11 weight; an evaluate request takes seven Q12.20
// features plus a bias of one, forms six hidden sums and three output sums (products
// floored by 2^11, each addition saturated to 48 bits) and returns one response.
// Requests are taken only while the sequencer is idle: an evaluation stalls the input
// until the sequencer is idle again, so a new evaluation is not taken before the last
// one has issued all its reads. The single read port of the weight memory delivers one
// row (one input across all hidden neurons, or one hidden neuron across all outputs) per
// cycle while a layer is walked: eight rows, then six rows, each read, multiplied and
// accumulated in turn. The output register frees the sequencer while a response waits;
// the next evaluation stalls before its output layer until that response is taken.
// Evaluating a slot whose weights were never written gives undefined values.
module two_layer_linear_network_eval_unit import tlne_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctl_type ctl;
   logic    idle;
   logic    rsp_full;
   logic    req_take;
   logic    slot_ok;
   logic    eval_go;
   logic    wr_en;
   logic    idx_ok;

   assign req_stall = !idle;
   assign req_take  = req_valid && idle;
   assign slot_ok   = (32'(req_data.slot) < CANDIDATE_SLOTS);
   assign idx_ok    = (32'(req_data.weight_index) < SLOT_WEIGHTS);
   assign eval_go   = req_take && slot_ok && (req_data.cmd == CMD_EVAL);
   assign wr_en     = req_take && slot_ok && idx_ok && (req_data.cmd == CMD_WRITE);

   tlne_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .eval_go  (eval_go),
      .rsp_full (rsp_full),
      .ctl      (ctl),
      .idle     (idle)
   );

   tlne_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .wr_en     (wr_en),
      .eval_go   (eval_go),
      .ctl       (ctl),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_full  (rsp_full)
   );

   // an accepted evaluation keeps the input closed
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      eval_go |=> req_stall)
      else $error("evaluation accepted but sequencer still idle");

   // a response only appears out of an evaluation in flight
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall, 2))
      else $error("response raised without an evaluation in flight");

   // memory reads never overlap a cycle that accepts requests
   a_issue_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.issue |-> req_stall)
      else $error("weight read issued while requests are accepted");

endmodule
